>>> src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the short-frame CRC-8 deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int MaxFrameBytes = 64;
    localparam int StoreAddrW    = 6;
    localparam int CountW        = 7;

    localparam logic [7:0]        CrcPoly  = 8'h4D;
    localparam logic [7:0]        HdrMark  = 8'h80;
    localparam logic [7:0]        LenMask  = 8'h3F;
    localparam logic [CountW-1:0] StoreMax = 7'd64;

    // Configuration register indexes.
    localparam logic CFG_CRC_ENABLE    = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    // Buffer kinds on the output.
    localparam logic KIND_UNFRAMED = 1'b0;
    localparam logic KIND_FRAME    = 1'b1;

    typedef struct packed {
        logic       start;
        logic [7:0] seed;
    } crc_cmd_t;

    typedef struct packed {
        logic              start;
        logic              kind;
        logic [7:0]        protocol;
        logic [CountW-1:0] length;
    } emit_cmd_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_SEND
    } emit_state_t;

endpackage

`default_nettype wire

>>> src/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> src/sfd_crc_serial.sv
// ----------------------------------------------------------------------------
// sfd_crc_serial
// Bit-serial CRC-8 (MSB first) that holds the running CRC register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_crc_serial
    import sfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire crc_cmd_t cmd,
    output logic [7:0]    crc,
    output logic          busy
);

    logic [7:0] crc_reg, crc_next;
    logic [2:0] bit_reg, bit_next;
    logic       busy_reg, busy_next;

    // One polynomial step per cycle; eight steps consume one seeded byte.
    always_comb
    begin
        crc_next  = crc_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (cmd.start)
        begin
            crc_next  = cmd.seed;
            bit_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next = {crc_reg[6:0], 1'b0} ^ (crc_reg[7] ? CrcPoly : 8'h00);
            bit_next = bit_reg + 3'd1;
            if (bit_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= 8'h00;
            bit_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            bit_reg  <= bit_next;
            busy_reg <= busy_next;
        end
    end

    assign crc  = crc_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> src/sfd_emit.sv
// ----------------------------------------------------------------------------
// sfd_emit
// Reads a held buffer out of the byte store and sends it one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_emit
    import sfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire emit_cmd_t             cmd,
    output logic                       busy,
    output logic [StoreAddrW-1:0]      raddr,
    input  wire logic [7:0]            rdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,  // protocol, byte, length, pad
    output logic                       m_axis_tuser,  // kind
    output logic                       m_axis_tlast
);

    emit_state_t state_reg, state_next;

    logic [StoreAddrW-1:0] idx_reg, idx_next;
    logic [CountW-1:0]     len_reg, len_next;
    logic                  kind_reg, kind_next;
    logic [7:0]            proto_reg, proto_next;

    logic                  valid_reg, valid_next;
    logic [7:0]            obyte_reg, obyte_next;
    logic                  olast_reg, olast_next;
    logic [7:0]            oproto_reg, oproto_next;
    logic [CountW-1:0]     olen_reg, olen_next;
    logic                  okind_reg, okind_next;

    logic out_free;
    logic is_final;

    assign out_free = !valid_reg || m_axis_tready;
    assign is_final = (CountW'(idx_reg) + CountW'(1)) == len_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = EM_READ;
                end
            end
            EM_READ:
            begin
                state_next = EM_SEND;
            end
            EM_SEND:
            begin
                if (out_free)
                begin
                    state_next = is_final ? EM_IDLE : EM_READ;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next    = idx_reg;
        len_next    = len_reg;
        kind_next   = kind_reg;
        proto_next  = proto_reg;
        valid_next  = valid_reg && !m_axis_tready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        oproto_next = oproto_reg;
        olen_next   = olen_reg;
        okind_next  = okind_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (cmd.start)
                begin
                    idx_next   = '0;
                    len_next   = cmd.length;
                    kind_next  = cmd.kind;
                    proto_next = cmd.protocol;
                end
            end
            EM_SEND:
            begin
                if (out_free)
                begin
                    valid_next  = 1'b1;
                    obyte_next  = rdata;
                    olast_next  = is_final;
                    oproto_next = proto_reg;
                    olen_next   = len_reg;
                    okind_next  = kind_reg;
                    idx_next    = idx_reg + StoreAddrW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        kind_reg   <= kind_next;
        proto_reg  <= proto_next;
        obyte_reg  <= obyte_next;
        olast_reg  <= olast_next;
        oproto_reg <= oproto_next;
        olen_reg   <= olen_next;
        okind_reg  <= okind_next;
    end

    assign busy          = (state_reg != EM_IDLE);
    assign raddr         = idx_reg;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, olen_reg, obyte_reg, oproto_reg};
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

`default_nettype wire

>>> src/short_frame_crc8_deframer_core.sv
// ----------------------------------------------------------------------------
// short_frame_crc8_deframer_core
// Splits a bursty byte stream into CRC-8 checked short frames and unframed data.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: in_byte[7:0], now_ticks[39:8]; tuser: burst_first;
//                       tlast: burst_last
//  m_axis    out        tdata: out_protocol[7:0], out_byte[15:8], out_length[22:16];
//                       tuser: out_kind; tlast: out_last
//  cfg       in         index 0 crc_enable, index 1 timeout_ticks
//
// A byte is parsed in the cycle of its transfer; a byte that is only stored lets the
// next transfer follow in the next cycle. A CRC update holds the input while the CRC
// unit steps through the byte bit by bit. Releasing a buffer holds it for one store
// read and one output load per byte, plus output stalls; a header that does both waits
// for the longer one. Reset clears the parse state but not the byte store, of which
// only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module short_frame_crc8_deframer_core
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // Input byte stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // in_byte, now_ticks
    input  wire logic        s_axis_tuser,   // burst_first
    input  wire logic        s_axis_tlast,   // burst_last
    // Output byte stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_protocol, out_byte, out_length, pad
    output logic             m_axis_tuser,   // out_kind
    output logic             m_axis_tlast    // out_last
);

    // Configuration registers.
    logic        crc_en_reg;
    logic [31:0] timeout_reg;

    // Parser state.
    logic              in_frame_reg, in_frame_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [CountW-1:0] expect_reg, expect_next;
    logic [31:0]       last_ticks_reg, last_ticks_next;
    logic [7:0]        first_byte_reg, first_byte_next;

    logic [7:0]  in_byte;
    logic [31:0] now_ticks;
    logic        accept;
    logic        timed_out;

    // Values after the timeout check.
    logic              frm;
    logic [CountW-1:0] cnt;
    logic [CountW-1:0] exp_len;
    logic [CountW-1:0] cnt_stored;

    logic                  wr_en;
    logic [StoreAddrW-1:0] wr_addr;
    logic [StoreAddrW-1:0] rd_addr;
    logic [7:0]            rd_data;

    crc_cmd_t   crc_cmd;
    logic [7:0] running_crc;
    logic       crc_busy;
    emit_cmd_t  emit_cmd;
    logic       emit_busy;

    assign in_byte   = s_axis_tdata[7:0];
    assign now_ticks = s_axis_tdata[39:8];

    // The input waits while the CRC unit or the emitter is still working.
    assign s_axis_tready = !crc_busy && !emit_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Wrapping tick difference compared only on the first byte of a burst.
    assign timed_out = s_axis_tuser && ((now_ticks - last_ticks_reg) > timeout_reg);

    assign frm        = timed_out ? 1'b0 : in_frame_reg;
    assign cnt        = timed_out ? '0 : count_reg;
    assign exp_len    = timed_out ? '0 : expect_reg;
    assign cnt_stored = cnt + CountW'(!cnt[CountW-1]);
    assign wr_addr    = cnt[StoreAddrW-1:0];

    // Parse one byte. At most one buffer is released per input byte, so the
    // emitter request is a single command.
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        count_next      = count_reg;
        expect_next     = expect_reg;
        last_ticks_next = last_ticks_reg;
        first_byte_next = first_byte_reg;
        wr_en           = 1'b0;
        crc_cmd         = '0;
        emit_cmd        = '0;

        if (accept)
        begin
            if (s_axis_tuser)
            begin
                last_ticks_next = now_ticks;
            end
            in_frame_next = frm;
            count_next    = cnt;
            expect_next   = exp_len;

            if (!frm)
            begin
                if (in_byte > HdrMark)
                begin
                    // Header: flush held unframed bytes, then open a frame.
                    if (cnt != '0)
                    begin
                        emit_cmd.start  = 1'b1;
                        emit_cmd.kind   = KIND_UNFRAMED;
                        emit_cmd.length = cnt;
                    end
                    count_next    = '0;
                    in_frame_next = 1'b1;
                    expect_next   = CountW'(in_byte & LenMask) + CountW'(1);
                    if (crc_en_reg)
                    begin
                        crc_cmd.start = 1'b1;
                        crc_cmd.seed  = in_byte;
                    end
                end
                else
                begin
                    wr_en      = !cnt[CountW-1];
                    count_next = cnt_stored;
                    if (cnt_stored[CountW-1])
                    begin
                        // The store is full of unframed bytes.
                        emit_cmd.start  = 1'b1;
                        emit_cmd.kind   = KIND_UNFRAMED;
                        emit_cmd.length = StoreMax;
                        count_next      = '0;
                    end
                end
            end
            else if (crc_en_reg && (cnt >= exp_len))
            begin
                // Trailing CRC byte: release the frame only if it matches.
                if ((in_byte == running_crc) && (cnt != '0))
                begin
                    emit_cmd.start    = 1'b1;
                    emit_cmd.kind     = KIND_FRAME;
                    emit_cmd.protocol = first_byte_reg;
                    emit_cmd.length   = cnt;
                end
                count_next    = '0;
                expect_next   = '0;
                in_frame_next = 1'b0;
            end
            else
            begin
                wr_en      = !cnt[CountW-1];
                count_next = cnt_stored;
                if (crc_en_reg)
                begin
                    crc_cmd.start = 1'b1;
                    crc_cmd.seed  = running_crc ^ in_byte;
                end
                else if (cnt_stored >= exp_len)
                begin
                    // Without CRC the frame is complete with its last payload byte.
                    emit_cmd.start    = 1'b1;
                    emit_cmd.kind     = KIND_FRAME;
                    emit_cmd.protocol = (wr_en && (cnt == '0)) ? in_byte : first_byte_reg;
                    emit_cmd.length   = cnt_stored;
                    count_next        = '0;
                    expect_next       = '0;
                    in_frame_next     = 1'b0;
                end
            end

            if (wr_en && (cnt == '0))
            begin
                first_byte_next = in_byte;
            end

            // End of burst flushes held unframed bytes.
            if (s_axis_tlast && !in_frame_next && (count_next != '0))
            begin
                emit_cmd.start    = 1'b1;
                emit_cmd.kind     = KIND_UNFRAMED;
                emit_cmd.protocol = 8'h00;
                emit_cmd.length   = count_next;
                count_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg     <= 1'b0;
            timeout_reg    <= 32'd1000;
            in_frame_reg   <= 1'b0;
            count_reg      <= '0;
            expect_reg     <= '0;
            last_ticks_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CRC_ENABLE:    crc_en_reg  <= cfg_wdata[0];
                    CFG_TIMEOUT_TICKS: timeout_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            in_frame_reg   <= in_frame_next;
            count_reg      <= count_next;
            expect_reg     <= expect_next;
            last_ticks_reg <= last_ticks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_byte_reg <= first_byte_next;
    end

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (MaxFrameBytes)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    sfd_crc_serial u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .crc   (running_crc),
        .busy  (crc_busy)
    );

    sfd_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (emit_cmd),
        .busy          (emit_busy),
        .raddr         (rd_addr),
        .rdata         (rd_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A CRC update only starts once the previous one has finished.
    a_crc_start: assert property (@(posedge clk) disable iff (!rst_n)
        crc_cmd.start |-> !crc_busy)
        else $error("CRC update started while the previous one runs");

    // Unframed data is flushed as soon as the store fills.
    a_unframed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (count_reg < StoreMax))
        else $error("unframed byte count reached the store size");

    // An open frame always has a payload length from its header.
    a_frame_length: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> ((expect_reg != '0) && (expect_reg <= StoreMax)))
        else $error("open frame without a valid payload length");

    // A buffer is only released while the emitter is free.
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cmd.start |-> (!emit_busy && (emit_cmd.length != '0)))
        else $error("buffer release while the emitter is busy or empty");

endmodule

`default_nettype wire

>>> bench/tb_short_frame_crc8_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_short_frame_crc8_deframer_core
// Self-checking bench for the short-frame CRC-8 deframer. A deframer model
// kept inside the bench predicts every output byte from the accepted input
// bytes. A checker process compares each output transfer with the oldest
// predicted byte. Directed bursts come first, then randomized burst traffic
// under several idle patterns and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_short_frame_crc8_deframer_core;

    import sfd_pkg::*;

    localparam logic [7:0] CRC8_POLY    = 8'h4D;
    localparam int         STORE_DEPTH  = 64;
    localparam int         SETTLE_CYCLES = 32;
    localparam int         HOLD_CYCLES  = 400;

    // One predicted or observed output byte.
    typedef struct packed {
        logic       kind;
        logic [7:0] protocol;
        logic [7:0] data;
        logic [6:0] length;
        logic       last;
    } out_byte_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // in_byte[7:0], now_ticks[39:8]
    logic        s_axis_tuser;   // burst_first
    logic        s_axis_tlast;   // burst_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // out_protocol[7:0], out_byte[15:8], out_length[22:16], pad
    logic        m_axis_tuser;   // out_kind
    logic        m_axis_tlast;   // out_last

    short_frame_crc8_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------

    // Output bytes predicted but not yet seen, oldest first.
    out_byte_t   expected_bytes[$];
    int          error_count = 0;
    int          sent_items  = 0;

    // Idle odds in percent per cycle for the input and the output side.
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;

    // The output hold-off is requested by bumping hold_asks; the checker
    // process notices the change and counts the stretch down on its own.
    int          hold_asks  = 0;
    int          hold_taken = 0;
    int          hold_left  = 0;

    // Bytes of the burst being built, and the tick time of the next burst.
    logic [7:0]  burst_q[$];
    logic [31:0] burst_ticks = 32'd0;

    // Deframer model: configuration and parse state.
    logic        dm_crc_on;
    logic [31:0] dm_timeout;
    logic        dm_in_frame;
    logic [7:0]  dm_crc;
    logic [7:0]  dm_store[STORE_DEPTH];
    int          dm_count;
    int          dm_frame_len;
    logic [31:0] dm_last_ticks;

    out_byte_t   got_byte;
    out_byte_t   want_byte;

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Deframer model.
    // ------------------------------------------------------------------------

    // Eight MSB-first shifts of the CRC-8 register.
    function automatic logic [7:0] crc8_shift(input logic [7:0] v);
        logic [7:0] r;
        int         k;
        r = v;
        for (k = 0; k < 8; k++)
        begin
            r = r[7] ? ((r << 1) ^ CRC8_POLY) : (r << 1);
        end
        return r;
    endfunction

    // Queues the held bytes as one output buffer of the given kind.
    task automatic release_buffer(input logic kind);
        out_byte_t ob;
        int        len;
        int        i;
        len = (dm_count > STORE_DEPTH) ? STORE_DEPTH : dm_count;
        for (i = 0; i < len; i++)
        begin
            ob.kind     = kind;
            ob.protocol = (kind == KIND_FRAME) ? dm_store[0] : 8'h00;
            ob.data     = dm_store[i];
            ob.length   = 7'(len);
            ob.last     = (i + 1 == len);
            expected_bytes.push_back(ob);
        end
    endtask

    task automatic clear_parse();
        dm_count     = 0;
        dm_frame_len = 0;
        dm_in_frame  = 1'b0;
    endtask

    // Advances the model by one accepted input byte.
    task automatic deframe_byte(input logic [7:0] b, input logic [31:0] ticks,
                                input logic first, input logic last);
        logic [31:0] gap;
        if (first)
        begin
            // Wrapping difference; strictly greater than the timeout clears.
            gap = ticks - dm_last_ticks;
            if (gap > dm_timeout)
            begin
                clear_parse();
            end
            dm_last_ticks = ticks;
        end

        if (!dm_in_frame)
        begin
            if (b > 8'h80)
            begin
                if (dm_count != 0)
                begin
                    release_buffer(KIND_UNFRAMED);
                    dm_count = 0;
                end
                dm_in_frame = 1'b1;
                if (dm_crc_on)
                begin
                    dm_crc = crc8_shift(b);
                end
                dm_frame_len = int'(b[5:0]) + 1;
            end
            else
            begin
                if (dm_count < STORE_DEPTH)
                begin
                    dm_store[dm_count] = b;
                    dm_count++;
                end
                if (dm_count >= STORE_DEPTH)
                begin
                    release_buffer(KIND_UNFRAMED);
                    dm_count = 0;
                end
            end
        end
        else if (dm_crc_on && dm_count >= dm_frame_len)
        begin
            // Trailing check byte against the CRC as it stands.
            if (b == dm_crc && dm_count != 0)
            begin
                release_buffer(KIND_FRAME);
            end
            clear_parse();
        end
        else
        begin
            if (dm_count < STORE_DEPTH)
            begin
                dm_store[dm_count] = b;
                dm_count++;
            end
            if (dm_crc_on)
            begin
                dm_crc = crc8_shift(dm_crc ^ b);
            end
            else if (dm_count >= dm_frame_len)
            begin
                release_buffer(KIND_FRAME);
                clear_parse();
            end
        end

        if (last && !dm_in_frame && dm_count != 0)
        begin
            release_buffer(KIND_UNFRAMED);
            dm_count = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready generation, hold-off and checking.
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_byte.kind     = m_axis_tuser;
                got_byte.protocol = m_axis_tdata[7:0];
                got_byte.data     = m_axis_tdata[15:8];
                got_byte.length   = m_axis_tdata[22:16];
                got_byte.last     = m_axis_tlast;
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected output byte, expected none, actual %0h",
                             $time, got_byte);
                    error_count++;
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    check_field("out_kind", 8'(want_byte.kind), 8'(got_byte.kind));
                    check_field("out_protocol", want_byte.protocol, got_byte.protocol);
                    check_field("out_byte", want_byte.data, got_byte.data);
                    check_field("out_length", 8'(want_byte.length), 8'(got_byte.length));
                    check_field("out_last", 8'(want_byte.last), 8'(got_byte.last));
                end
            end

            // A new hold-off request starts a long stretch with ready low.
            if (hold_asks != hold_taken)
            begin
                hold_taken = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Offers one byte, with random idle cycles ahead of it, and returns at
    // the clock edge of its transfer.
    task automatic send_byte(input logic [7:0] b, input logic [31:0] ticks,
                             input logic first, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ticks, b};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        deframe_byte(b, ticks, first, last);
        sent_items++;
    endtask

    // Sends burst_q as one burst at the given tick time. Only the first byte
    // carries meaningful ticks; the others get random values, which the
    // block must ignore.
    task automatic send_burst(input logic [31:0] ticks, input bit mark_last);
        int i;
        for (i = 0; i < burst_q.size(); i++)
        begin
            send_byte(burst_q[i], (i == 0) ? ticks : $urandom, i == 0,
                      mark_last && (i == burst_q.size() - 1));
        end
    endtask

    // Appends a frame of len payload bytes, optionally with its check byte,
    // which may be corrupted.
    task automatic add_frame(input int len, input bit with_check, input bit corrupt);
        logic [7:0] hdr;
        logic [7:0] crc;
        logic [7:0] b;
        int         i;
        hdr = 8'h80 | 8'(len - 1);
        // Bit 6 is free; a one-byte frame needs it set to stay above 0x80.
        if (len == 1 || $urandom_range(1) == 1)
        begin
            hdr[6] = 1'b1;
        end
        burst_q.push_back(hdr);
        crc = crc8_shift(hdr);
        for (i = 0; i < len; i++)
        begin
            b = $urandom_range(255);
            burst_q.push_back(b);
            crc = crc8_shift(crc ^ b);
        end
        if (with_check)
        begin
            burst_q.push_back(corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc);
        end
    endtask

    // Drops valid and waits until every predicted byte has come out, plus a
    // margin for a CRC update that is still running.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only called while the block is idle. The enable is
    // dropped for one cycle so that writes never run into each other.
    task automatic write_cfg(input logic idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CRC_ENABLE)
        begin
            dm_crc_on = value[0];
        end
        else
        begin
            dm_timeout = value;
        end
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Directed bursts under the reset configuration (CRC off, timeout 1000)
    // and then with CRC on.
    task automatic test_directed();
        // The byte 0x80 is not a header and is held like any data byte.
        burst_q = '{8'h00, 8'h80, 8'h7F};
        send_burst(32'd10, 1'b1);
        // One-byte frame whose protocol byte is all ones.
        burst_q = '{8'hC0, 8'hFF};
        send_burst(32'd20, 1'b1);
        // A header flushes the held bytes; the frame stays open at burst end.
        burst_q = '{8'h12, 8'h34, 8'h82, 8'hAA, 8'hBB};
        send_burst(32'd30, 1'b0);
        // A gap of exactly the timeout does not clear the open frame.
        burst_q = '{8'hCC};
        send_burst(32'd1030, 1'b1);
        // A gap one tick past the timeout discards the partial frame.
        burst_q = '{8'h83, 8'h01};
        send_burst(32'd1040, 1'b0);
        burst_q = '{8'h05};
        send_burst(32'd2041, 1'b1);

        settle();
        write_cfg(CFG_CRC_ENABLE, 32'd1);
        write_cfg(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        // Ticks wrap back to zero; with the largest timeout nothing clears.
        burst_q.delete();
        add_frame(2, 1'b1, 1'b0);
        send_burst(32'd0, 1'b1);
        // A bad check byte drops the frame.
        burst_q.delete();
        add_frame(1, 1'b1, 1'b1);
        send_burst(32'd7, 1'b1);
        burst_ticks = 32'd7;
    endtask

    // CRC enable toggled while a frame is open.
    task automatic test_crc_switch_mid_frame();
        // CRC on, full payload received, then CRC off: the next byte is
        // stored and the frame goes out at once.
        settle();
        write_cfg(CFG_CRC_ENABLE, 32'd1);
        burst_q = '{8'h81, 8'h11, 8'h22};
        send_burst(burst_ticks, 1'b0);
        settle();
        write_cfg(CFG_CRC_ENABLE, 32'd0);
        burst_q = '{8'h33};
        send_burst(burst_ticks + 32'd1, 1'b1);

        // CRC off at the header and the first payload byte, so the running CRC keeps its old value;
        // CRC on for the rest, and the check byte must match that CRC.
        settle();
        burst_q = '{8'h82, 8'h44};
        send_burst(burst_ticks + 32'd2, 1'b0);
        settle();
        write_cfg(CFG_CRC_ENABLE, 32'd1);
        burst_q = '{8'h55, 8'h66};
        send_burst(burst_ticks + 32'd3, 1'b0);
        send_byte(dm_crc, $urandom, 1'b0, 1'b1);
        burst_ticks = burst_ticks + 32'd3;
    endtask

    // Unframed overflow at 64 held bytes; the byte after it is flushed at
    // the end of the burst.
    task automatic test_full_store();
        int i;
        settle();
        write_cfg(CFG_CRC_ENABLE, 32'd0);
        burst_q.delete();
        for (i = 0; i < 65; i++)
        begin
            burst_q.push_back(8'($urandom_range(0, 128)));
        end
        send_burst(burst_ticks, 1'b1);
    endtask

    // Random bursts: mostly well-formed frames with random content, the rest
    // truncated frames, plain data and raw noise.
    task automatic test_random_bursts(input int n_items);
        int          target;
        int          segs;
        int          pick;
        int          len;
        int          i;
        int          cut;
        logic [31:0] step;
        target = sent_items + n_items;
        while (sent_items < target)
        begin
            burst_q.delete();
            segs = $urandom_range(1, 3);
            repeat (segs)
            begin
                pick = $urandom_range(99);
                len  = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
                if (pick < 55)
                begin
                    // Check byte present when CRC is on, now and then the wrong way.
                    add_frame(len, ($urandom_range(9) == 0) ? !dm_crc_on : dm_crc_on,
                              $urandom_range(99) < 15);
                end
                else if (pick < 65)
                begin
                    add_frame(len, dm_crc_on, 1'b0);
                    cut = $urandom_range(1, len);
                    repeat (cut) void'(burst_q.pop_back());
                end
                else if (pick < 85)
                begin
                    for (i = 0; i < len; i++)
                    begin
                        burst_q.push_back(8'($urandom_range(0, 128)));
                    end
                end
                else
                begin
                    for (i = 0; i < len; i++)
                    begin
                        burst_q.push_back(8'($urandom_range(255)));
                    end
                end
            end

            // Gap since the last burst: inside, at, and past the timeout.
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                step = $urandom_range(0, (dm_timeout > 5000) ? 5000 : dm_timeout);
            end
            else if (pick < 70)
            begin
                step = dm_timeout;
            end
            else if (pick < 85)
            begin
                step = dm_timeout + 32'd1;
            end
            else
            begin
                step = $urandom;
            end
            burst_ticks = burst_ticks + step;
            send_burst(burst_ticks, $urandom_range(99) < 80);
        end
    endtask

    // The output side holds off for a long stretch while frames keep coming,
    // so the block fills up and stalls its input.
    task automatic test_output_hold();
        int k;
        settle();
        hold_asks++;
        for (k = 0; k < 4; k++)
        begin
            burst_q.delete();
            add_frame($urandom_range(2, 6), dm_crc_on, 1'b0);
            burst_q.push_back(8'($urandom_range(0, 128)));
            burst_ticks = burst_ticks + 32'd1;
            send_burst(burst_ticks, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_CRC_ENABLE;
        cfg_wdata     <= 32'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 40'd0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b1;

        // Model state after reset.
        dm_crc_on     = 1'b0;
        dm_timeout    = 32'd1000;
        dm_in_frame   = 1'b0;
        dm_crc        = 8'h00;
        dm_count      = 0;
        dm_frame_len  = 0;
        dm_last_ticks = 32'd0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles 20 percent, receiver 69 percent.
        src_idle_pct  = 20;
        sink_idle_pct = 69;
        test_directed();
        test_crc_switch_mid_frame();
        settle();
        write_cfg(CFG_CRC_ENABLE, 32'd1);
        write_cfg(CFG_TIMEOUT_TICKS, 32'($urandom_range(50, 3000)));
        test_random_bursts(10);

        // The other way round, with CRC off and timeouts never firing.
        src_idle_pct  = 69;
        sink_idle_pct = 20;
        settle();
        write_cfg(CFG_CRC_ENABLE, 32'd0);
        write_cfg(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        test_random_bursts(10);

        // No idling; CRC on and a zero timeout, so any tick advance clears.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        settle();
        write_cfg(CFG_CRC_ENABLE, 32'd1);
        write_cfg(CFG_TIMEOUT_TICKS, 32'd0);
        test_random_bursts(10);

        settle();
        write_cfg(CFG_TIMEOUT_TICKS, 32'd1000);
        test_full_store();
        test_output_hold();

        settle();
        if (error_count == 0)
        begin
            $display("tb_short_frame_crc8_deframer_core OK");
        end
        else
        begin
            $display("tb_short_frame_crc8_deframer_core NOT OK");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("tb_short_frame_crc8_deframer_core NOT OK");
        $finish;
    end

endmodule
